// File: src/event_priority_queue_macros.svh
// Assertion helpers for the event queue checker.
`ifndef EVENT_PRIORITY_QUEUE_MACROS_SVH
`define EVENT_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clock, idle during reset.
`define EPQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("event queue check failed");

// Next-cycle implication, sampled on clock, idle during reset.
`define EPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("event queue check failed");

`endif

// File: src/epq_pkg.sv
`default_nettype none

package epq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_POP    = 2'd1,
      MODE_PEEK   = 2'd2
   } epq_mode_type;

   // transition codes that change same-process ordering
   localparam logic [2:0] TRANS_URGENT = 3'd3;
   localparam logic [2:0] TRANS_YIELD  = 3'd4;

   typedef struct packed {
      logic [31:0] stamp;
      logic [7:0]  pid;
      logic [2:0]  trans;
      logic [2:0]  st;
      logic [2:0]  prev;
   } epq_event_type;

   // command broadcast to every cell for one request
   typedef struct packed {
      logic          insert;
      logic          pop;
      logic          done;
      epq_event_type ev;
   } epq_cmd_type;

endpackage

`default_nettype wire

// File: src/event_priority_queue.sv
// Channel | Direction | Handshake           | Payload
// req_    | in        | req_valid/req_stall | mode, event fields, proc_done
// rsp_    | out       | rsp_valid/rsp_stall | head event, flags
//
// One request per cycle while req_stall is low; each result is registered and
// appears in the cycle after its request. All slots compare against the new event
// at once and the whole row shifts together; the head always sits in cell 0.
// Reset empties the queue.
// req_stall is high while a result waits and rsp_stall is high.
`default_nettype none

module event_priority_queue #(
   parameter int QUEUE_DEPTH = epq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [31:0] req_event_time,
   input  wire logic [7:0]  req_proc_id,
   input  wire logic [2:0]  req_trans_code,
   input  wire logic [2:0]  req_new_state,
   input  wire logic [2:0]  req_prior_state,
   input  wire logic        req_proc_done,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_out_time,
   output logic [7:0]       rsp_out_proc_id,
   output logic [2:0]       rsp_out_trans_code,
   output logic [2:0]       rsp_out_state,
   output logic [2:0]       rsp_out_prior_state,
   output logic             rsp_out_valid,
   output logic             rsp_queue_nonempty,
   output logic             rsp_insert_dropped
);

   epq_pkg::epq_cmd_type   cmd;
   epq_pkg::epq_event_type slot_vec  [QUEUE_DEPTH:0];
   logic [QUEUE_DEPTH:0]   occ_vec;
   logic [QUEUE_DEPTH-1:0] shift_vec;
   logic [QUEUE_DEPTH:0]   above_vec;

   logic                   accept;
   logic                   is_insert, is_pop, is_peek;
   logic                   full;

   logic                   rsp_valid_ff, rsp_valid_in;
   epq_pkg::epq_event_type rsp_ev_ff, rsp_ev_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic                   rsp_nonempty_ff, rsp_nonempty_in;
   logic                   rsp_drop_ff, rsp_drop_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = occ_vec[QUEUE_DEPTH-1];

   always_comb begin
      is_insert = 1'b0;
      is_pop    = 1'b0;
      is_peek   = 1'b0;
      unique case (req_mode)
         epq_pkg::MODE_INSERT: is_insert = 1'b1;
         epq_pkg::MODE_POP:    is_pop    = 1'b1;
         epq_pkg::MODE_PEEK:   is_peek   = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      cmd.insert   = accept && is_insert && !full;
      cmd.pop      = accept && is_pop && occ_vec[0];
      cmd.done     = req_proc_done;
      cmd.ev.stamp = req_event_time;
      cmd.ev.pid   = req_proc_id;
      cmd.ev.trans = req_trans_code;
      cmd.ev.st    = req_new_state;
      cmd.ev.prev  = req_prior_state;
   end

   assign occ_vec[QUEUE_DEPTH]   = 1'b0;
   assign slot_vec[QUEUE_DEPTH]  = '0;
   assign above_vec[QUEUE_DEPTH] = 1'b0;

   for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
      logic                   head_occ;
      logic                   head_shift;
      epq_pkg::epq_event_type head_slot;

      if (j == 0) begin : g_head
         assign head_occ   = 1'b1;
         assign head_shift = 1'b0;
         assign head_slot  = '0;
      end else begin : g_body
         assign head_occ   = occ_vec[j-1];
         assign head_shift = shift_vec[j-1];
         assign head_slot  = slot_vec[j-1];
      end

      epq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .head_occ   (head_occ),
         .head_shift (head_shift),
         .head_slot  (head_slot),
         .tail_occ   (occ_vec[j+1]),
         .tail_slot  (slot_vec[j+1]),
         .above_in   (above_vec[j+1]),
         .occ        (occ_vec[j]),
         .shift      (shift_vec[j]),
         .above_out  (above_vec[j]),
         .slot       (slot_vec[j])
      );
   end

   always_comb begin
      rsp_ev_in       = rsp_ev_ff;
      rsp_hit_in      = rsp_hit_ff;
      rsp_nonempty_in = rsp_nonempty_ff;
      rsp_drop_in     = rsp_drop_ff;
      if (accept) begin
         rsp_hit_in      = (is_pop || is_peek) && occ_vec[0];
         rsp_ev_in       = rsp_hit_in ? slot_vec[0] : '0;
         rsp_drop_in     = is_insert && full;
         // after a pop only cell 1 tells whether anything is left
         rsp_nonempty_in = is_insert || (is_pop ? occ_vec[1] : occ_vec[0]);
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ev_ff       <= rsp_ev_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_nonempty_ff <= rsp_nonempty_in;
      rsp_drop_ff     <= rsp_drop_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_time        = rsp_ev_ff.stamp;
   assign rsp_out_proc_id     = rsp_ev_ff.pid;
   assign rsp_out_trans_code  = rsp_ev_ff.trans;
   assign rsp_out_state       = rsp_ev_ff.st;
   assign rsp_out_prior_state = rsp_ev_ff.prev;
   assign rsp_out_valid       = rsp_hit_ff;
   assign rsp_queue_nonempty  = rsp_nonempty_ff;
   assign rsp_insert_dropped  = rsp_drop_ff;

endmodule

`default_nettype wire

// File: src/epq_cell.sv
`default_nettype none

// One queue slot. Head side neighbor is j-1, tail side neighbor is j+1.
module epq_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire epq_pkg::epq_cmd_type  cmd,
   input  wire logic                  head_occ,
   input  wire logic                  head_shift,
   input  wire epq_pkg::epq_event_type head_slot,
   input  wire logic                  tail_occ,
   input  wire epq_pkg::epq_event_type tail_slot,
   input  wire logic                  above_in,
   output logic                       occ,
   output logic                       shift,
   output logic                       above_out,
   output epq_pkg::epq_event_type     slot
);

   epq_pkg::epq_event_type slot_ff, slot_in;
   logic                   occ_ff, occ_in;
   logic                   trails;
   logic                   stop_here;
   logic                   ins_here;

   always_comb begin
      if (cmd.ev.pid == slot_ff.pid) begin
         trails = cmd.done || (cmd.ev.trans == epq_pkg::TRANS_URGENT) ||
                  ((slot_ff.trans != epq_pkg::TRANS_URGENT) &&
                   (cmd.ev.trans == epq_pkg::TRANS_YIELD));
      end else begin
         trails = cmd.ev.stamp < slot_ff.stamp;
      end
   end

   // stop_here: this cell holds a blocker; above_out carries any blocker toward the head
   assign stop_here = occ_ff && !trails;
   assign above_out = above_in || stop_here;
   assign shift     = occ_ff && !stop_here && !above_in;
   assign ins_here  = head_occ && !head_shift && (shift || !occ_ff);

   always_comb begin
      slot_in = slot_ff;
      occ_in  = occ_ff;
      if (cmd.insert) begin
         if (head_shift) begin
            slot_in = head_slot;
            occ_in  = 1'b1;
         end else if (ins_here) begin
            slot_in = cmd.ev;
            occ_in  = 1'b1;
         end
      end else if (cmd.pop) begin
         slot_in = tail_slot;
         occ_in  = tail_occ;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign occ  = occ_ff;
   assign slot = slot_ff;

endmodule

`default_nettype wire

// File: src/epq_checker.sv
`default_nettype none

`include "event_priority_queue_macros.svh"

module epq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_out_time,
   input wire logic [7:0]  rsp_out_proc_id,
   input wire logic [2:0]  rsp_out_trans_code,
   input wire logic [2:0]  rsp_out_state,
   input wire logic [2:0]  rsp_out_prior_state,
   input wire logic        rsp_out_valid,
   input wire logic        rsp_queue_nonempty,
   input wire logic        rsp_insert_dropped
);

   // a waiting result is not withdrawn
   `EPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

   // request side only backs up behind a waiting result
   `EPQ_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall)

   // no event reported means all event fields are zero
   `EPQ_ASSERT_NOW(a_empty_fields, rsp_valid && !rsp_out_valid,
      rsp_out_time == 32'd0 && rsp_out_proc_id == 8'd0 && rsp_out_trans_code == 3'd0 &&
      rsp_out_state == 3'd0 && rsp_out_prior_state == 3'd0)

   // a dropped insert came from a full queue and reports no event
   `EPQ_ASSERT_NOW(a_drop_full, rsp_valid && rsp_insert_dropped,
      !rsp_out_valid && rsp_queue_nonempty)

endmodule

bind event_priority_queue epq_checker u_epq_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_out_time        (rsp_out_time),
   .rsp_out_proc_id     (rsp_out_proc_id),
   .rsp_out_trans_code  (rsp_out_trans_code),
   .rsp_out_state       (rsp_out_state),
   .rsp_out_prior_state (rsp_out_prior_state),
   .rsp_out_valid       (rsp_out_valid),
   .rsp_queue_nonempty  (rsp_queue_nonempty),
   .rsp_insert_dropped  (rsp_insert_dropped)
);

`default_nettype wire

// File: tb/event_order_checker.sv
module event_order_checker #(
   parameter int DEPTH = epq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_event_time,
   input  logic [7:0]  req_proc_id,
   input  logic [2:0]  req_trans_code,
   input  logic [2:0]  req_new_state,
   input  logic [2:0]  req_prior_state,
   input  logic        req_proc_done,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_out_time,
   input  logic [7:0]  rsp_out_proc_id,
   input  logic [2:0]  rsp_out_trans_code,
   input  logic [2:0]  rsp_out_state,
   input  logic [2:0]  rsp_out_prior_state,
   input  logic        rsp_out_valid,
   input  logic        rsp_queue_nonempty,
   input  logic        rsp_insert_dropped,
   output int          fail_count,
   output int          outstanding,
   output int          request_count,
   output int          events_reported,
   output int          inserts_refused
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      epq_pkg::epq_event_type ev;
      logic                   found;
      logic                   nonempty;
      logic                   dropped;
   } queue_result_type;

   // shadow copy of the queue: slot 0 is the latest end, slot count-1 the head
   epq_pkg::epq_event_type shadow_slots [DEPTH];
   int                     shadow_count;
   queue_result_type       expected_results [$];

   int failures = 0;
   int pending = 0;
   int requests = 0;
   int reported = 0;
   int refused = 0;

   assign fail_count      = failures;
   assign outstanding     = pending;
   assign request_count   = requests;
   assign events_reported = reported;
   assign inserts_refused = refused;

   function automatic bit lands_behind(epq_pkg::epq_event_type incoming, logic done,
                                       epq_pkg::epq_event_type stored);
      if (incoming.pid == stored.pid) begin
         if (done) return 1'b1;
         if (incoming.trans == epq_pkg::TRANS_URGENT) return 1'b1;
         if (stored.trans == epq_pkg::TRANS_URGENT) return 1'b0;
         return incoming.trans == epq_pkg::TRANS_YIELD;
      end
      return incoming.stamp < stored.stamp;
   endfunction

   function automatic queue_result_type apply_request(logic [1:0] mode,
                                                      epq_pkg::epq_event_type ev,
                                                      logic done);
      queue_result_type r;
      int pos;
      r = '0;
      case (mode)
         epq_pkg::MODE_INSERT: begin
            if (shadow_count >= DEPTH) begin
               r.dropped = 1'b1;
            end else begin
               pos = shadow_count;
               for (int i = 0; i < shadow_count; i++) begin
                  if (!lands_behind(ev, done, shadow_slots[i])) begin
                     pos = i;
                     break;
                  end
               end
               for (int i = shadow_count; i > pos; i--)
                  shadow_slots[i] = shadow_slots[i - 1];
               shadow_slots[pos] = ev;
               shadow_count++;
            end
         end
         epq_pkg::MODE_POP, epq_pkg::MODE_PEEK: begin
            if (shadow_count > 0) begin
               r.ev    = shadow_slots[shadow_count - 1];
               r.found = 1'b1;
               if (mode == epq_pkg::MODE_POP) shadow_count--;
            end
         end
         default: ;
      endcase
      r.nonempty = shadow_count > 0;
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch
      queue_result_type       want;
      epq_pkg::epq_event_type req_ev;
      if (reset) begin
         shadow_count = 0;
         expected_results.delete();
      end else begin
         // a result always leaves after its request, so retire before adding
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result accepted with no request outstanding");
               failures++;
            end else begin
               want = expected_results.pop_front();
               check_field("out_time", want.ev.stamp, rsp_out_time);
               check_field("out_proc_id", 32'(want.ev.pid), 32'(rsp_out_proc_id));
               check_field("out_trans_code", 32'(want.ev.trans),
                           32'(rsp_out_trans_code));
               check_field("out_state", 32'(want.ev.st), 32'(rsp_out_state));
               check_field("out_prior_state", 32'(want.ev.prev),
                           32'(rsp_out_prior_state));
               check_field("out_valid", 32'(want.found), 32'(rsp_out_valid));
               check_field("queue_nonempty", 32'(want.nonempty),
                           32'(rsp_queue_nonempty));
               check_field("insert_dropped", 32'(want.dropped),
                           32'(rsp_insert_dropped));
               if (want.found) reported++;
            end
         end
         if (req_valid && !req_stall) begin
            req_ev.stamp = req_event_time;
            req_ev.pid   = req_proc_id;
            req_ev.trans = req_trans_code;
            req_ev.st    = req_new_state;
            req_ev.prev  = req_prior_state;
            want = apply_request(req_mode, req_ev, req_proc_done);
            if (want.dropped) refused++;
            expected_results = {expected_results, want};
            requests++;
         end
      end
      pending = expected_results.size();
   end

endmodule

// File: tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]  MODE_UNUSED     = 2'd3;
   localparam int          HOLD_OFF_CYCLES = 200;
   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int          PHASE_ITEMS     = 480;

   typedef struct packed {
      logic [1:0]             mode;
      epq_pkg::epq_event_type ev;
      logic                   done;
   } request_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic [31:0] req_event_time;
   logic [7:0]  req_proc_id;
   logic [2:0]  req_trans_code;
   logic [2:0]  req_new_state;
   logic [2:0]  req_prior_state;
   logic        req_proc_done;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_out_time;
   logic [7:0]  rsp_out_proc_id;
   logic [2:0]  rsp_out_trans_code;
   logic [2:0]  rsp_out_state;
   logic [2:0]  rsp_out_prior_state;
   logic        rsp_out_valid;
   logic        rsp_queue_nonempty;
   logic        rsp_insert_dropped;

   int fail_count;
   int outstanding;
   int request_count;
   int events_reported;
   int inserts_refused;

   int          idle_pct = 0;
   int          stall_pct = 0;
   logic        hold_off_go = 1'b0;
   int unsigned cycle_count = 0;

   event_priority_queue uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_event_time     (req_event_time),
      .req_proc_id        (req_proc_id),
      .req_trans_code     (req_trans_code),
      .req_new_state      (req_new_state),
      .req_prior_state    (req_prior_state),
      .req_proc_done      (req_proc_done),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_time       (rsp_out_time),
      .rsp_out_proc_id    (rsp_out_proc_id),
      .rsp_out_trans_code (rsp_out_trans_code),
      .rsp_out_state      (rsp_out_state),
      .rsp_out_prior_state(rsp_out_prior_state),
      .rsp_out_valid      (rsp_out_valid),
      .rsp_queue_nonempty (rsp_queue_nonempty),
      .rsp_insert_dropped (rsp_insert_dropped)
   );

   event_order_checker u_order_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_event_time     (req_event_time),
      .req_proc_id        (req_proc_id),
      .req_trans_code     (req_trans_code),
      .req_new_state      (req_new_state),
      .req_prior_state    (req_prior_state),
      .req_proc_done      (req_proc_done),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_time       (rsp_out_time),
      .rsp_out_proc_id    (rsp_out_proc_id),
      .rsp_out_trans_code (rsp_out_trans_code),
      .rsp_out_state      (rsp_out_state),
      .rsp_out_prior_state(rsp_out_prior_state),
      .rsp_out_valid      (rsp_out_valid),
      .rsp_queue_nonempty (rsp_queue_nonempty),
      .rsp_insert_dropped (rsp_insert_dropped),
      .fail_count         (fail_count),
      .outstanding        (outstanding),
      .request_count      (request_count),
      .events_reported    (events_reported),
      .inserts_refused    (inserts_refused)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic request_type make_request(logic [1:0] mode, logic [31:0] t,
                                                logic [7:0] pid, logic [2:0] tr,
                                                logic [2:0] st, logic [2:0] pv,
                                                logic done);
      request_type r;
      r.mode     = mode;
      r.ev.stamp = t;
      r.ev.pid   = pid;
      r.ev.trans = tr;
      r.ev.st    = st;
      r.ev.prev  = pv;
      r.done     = done;
      return r;
   endfunction

   // few pids and narrow times so same-process ordering and ties come up often
   function automatic request_type random_request(int insert_pct);
      request_type r;
      int pick;
      pick = $urandom_range(99);
      if (pick < insert_pct) r.mode = epq_pkg::MODE_INSERT;
      else if (pick < 97)
         r.mode = ($urandom_range(3) != 0) ? epq_pkg::MODE_POP : epq_pkg::MODE_PEEK;
      else r.mode = MODE_UNUSED;
      r.ev.stamp = $urandom_range(1) ? $urandom_range(15) : $urandom();
      r.ev.pid   = ($urandom_range(3) != 0) ? 8'($urandom_range(3)) :
                                              8'($urandom_range(255));
      if ($urandom_range(4) < 2)
         r.ev.trans = $urandom_range(1) ? epq_pkg::TRANS_URGENT : epq_pkg::TRANS_YIELD;
      else
         r.ev.trans = 3'($urandom_range(7));
      r.ev.st   = 3'($urandom_range(7));
      r.ev.prev = 3'($urandom_range(7));
      r.done    = ($urandom_range(3) == 0);
      return r;
   endfunction

   task automatic send_request(input request_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= r.mode;
      req_event_time  <= r.ev.stamp;
      req_proc_id     <= r.ev.pid;
      req_trans_code  <= r.ev.trans;
      req_new_state   <= r.ev.st;
      req_prior_state <= r.ev.prev;
      req_proc_done   <= r.done;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin : receiver
      bit held;
      held = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         // one long hold-off so the block pushes back on requests
         if (hold_off_go && !held) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            held = 1'b1;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin : stimulus
      int sent;
      int burst;
      int insert_pct;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_mode        <= epq_pkg::MODE_INSERT;
      req_event_time  <= '0;
      req_proc_id     <= '0;
      req_trans_code  <= '0;
      req_new_state   <= '0;
      req_prior_state <= '0;
      req_proc_done   <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty queue: pop, peek and the unused mode report nothing
      send_request(make_request(epq_pkg::MODE_POP, '1, 8'hFF, 3'd7, 3'd7, 3'd7, 1'b1));
      send_request(make_request(epq_pkg::MODE_PEEK, '1, 8'hFF, 3'd7, 3'd7, 3'd7, 1'b1));
      send_request(make_request(MODE_UNUSED, '1, 8'hFF, 3'd7, 3'd7, 3'd7, 1'b1));
      // timestamp extremes across different processes
      send_request(make_request(epq_pkg::MODE_INSERT, 32'd100, 8'd1, 3'd0, 3'd1, 3'd2,
                                1'b0));
      send_request(make_request(epq_pkg::MODE_INSERT, 32'd0, 8'd2, 3'd0, 3'd0, 3'd0,
                                1'b0));
      send_request(make_request(epq_pkg::MODE_INSERT, '1, 8'hFF, 3'd7, 3'd7, 3'd7,
                                1'b0));
      send_request(make_request(epq_pkg::MODE_INSERT, 32'd100, 8'd3, 3'd1, 3'd5, 3'd6,
                                1'b0));
      // same process: urgent, yield, done and plain codes
      send_request(make_request(epq_pkg::MODE_INSERT, 32'd5, 8'd1, epq_pkg::TRANS_URGENT,
                                3'd2, 3'd3, 1'b0));
      send_request(make_request(epq_pkg::MODE_INSERT, 32'd6, 8'd1, epq_pkg::TRANS_YIELD,
                                3'd4, 3'd5, 1'b0));
      send_request(make_request(epq_pkg::MODE_INSERT, 32'd7, 8'd1, 3'd0, 3'd6, 3'd7,
                                1'b1));
      send_request(make_request(epq_pkg::MODE_INSERT, 32'd8, 8'd1, 3'd2, 3'd1, 3'd1,
                                1'b0));
      send_request(make_request(epq_pkg::MODE_INSERT, 32'd9, 8'd1, epq_pkg::TRANS_URGENT,
                                3'd3, 3'd0, 1'b1));
      send_request(make_request(epq_pkg::MODE_INSERT, 32'd9, 8'd1, epq_pkg::TRANS_YIELD,
                                3'd0, 3'd4, 1'b1));
      send_request(make_request(MODE_UNUSED, 32'd0, 8'd0, 3'd0, 3'd0, 3'd0, 1'b0));
      send_request(make_request(epq_pkg::MODE_PEEK, 32'd0, 8'd0, 3'd0, 3'd0, 3'd0, 1'b0));
      repeat (10)
         send_request(make_request(epq_pkg::MODE_POP, 32'd0, 8'd0, 3'd0, 3'd0, 3'd0,
                                   1'b0));

      // receiver holds off while the sender keeps pushing inserts
      hold_off_go <= 1'b1;
      repeat (40) send_request(random_request(85));

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 63; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 63; end
            default: begin idle_pct = 13; stall_pct = 13; end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            // bursts swing the queue between full and empty
            burst = $urandom_range(4, 40);
            case ($urandom_range(2))
               0: insert_pct = 85;
               1: insert_pct = 15;
               default: insert_pct = 50;
            endcase
            repeat (burst) send_request(random_request(insert_pct));
            sent += burst;
         end
      end

      req_valid <= 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Ran %0d requests through reset, directed ordering cases, a long",
               request_count);
      $display("response hold-off and four idle/stall mixes: %0d events out, %0d refused",
               events_reported, inserts_refused);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
